[hw/rtl/fdl_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the FIR filter delay line unit.
package fdl_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int ACTION_W    = 3;
  localparam int INDEX_W     = 6;
  localparam int TAPCNT_W    = 7;
  localparam int SHIFT_W     = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;

  localparam logic [ACTION_W-1:0] ACT_SAMPLE    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_WR_COEF   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_WR_DELAY  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_RD_DELAY  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLR_DELAY = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_SHIFT = 1'b1;

  typedef struct packed {
    logic [ACTION_W-1:0]           action;
    logic [INDEX_W-1:0]            entry_index;
    logic signed [SAMPLE_BITS-1:0] data_value;
    logic                          is_last;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_value;
    logic                          out_last;
    logic                          out_error;
  } out_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

[hw/rtl/fdl_mac.sv]
`timescale 1ns / 1ps
// Two-stage multiply-accumulate unit, one tap per cycle.
module fdl_mac #(
  parameter int ACC_W = 38
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  fdl_pkg::mac_ctl_t                      ctl,
  input  logic signed [fdl_pkg::SAMPLE_BITS-1:0] coef,
  input  logic signed [fdl_pkg::SAMPLE_BITS-1:0] operand,
  output logic signed [ACC_W-1:0]                acc,
  output logic                                   done
);

  localparam int SB = fdl_pkg::SAMPLE_BITS;

  fdl_pkg::mac_ctl_t        ctl_r;
  logic                     done_r;
  logic signed [2*SB-1:0]   prod_r;
  logic signed [2*SB-1:0]   prod_nxt;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;

  always_comb begin
    prod_nxt = coef * operand;
    prod_ext = ACC_W'(prod_r);
    acc_nxt  = acc_r;
    if (ctl_r.vld) begin
      acc_nxt = ctl_r.first ? prod_ext : acc_r + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= '0;
      done_r <= 1'b0;
    end else begin
      ctl_r  <= ctl;
      done_r <= ctl_r.vld & ctl_r.last;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

[hw/rtl/fdl_shift_sat.sv]
`timescale 1ns / 1ps
// Bit-serial arithmetic right shifter with saturation to the sample width.
module fdl_shift_sat #(
  parameter int ACC_W = 38
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [ACC_W-1:0]                acc_in,
  input  logic [fdl_pkg::SHIFT_W-1:0]            shamt,
  output logic                                   done,
  output logic signed [fdl_pkg::SAMPLE_BITS-1:0] sat_value
);

  localparam int SB = fdl_pkg::SAMPLE_BITS;
  localparam logic signed [SB-1:0] SAT_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SAT_MIN = {1'b1, {(SB-1){1'b0}}};

  logic                         busy_r;
  logic                         busy_nxt;
  logic [fdl_pkg::SHIFT_W-1:0]  cnt_r;
  logic [fdl_pkg::SHIFT_W-1:0]  cnt_nxt;
  logic signed [ACC_W-1:0]      sh_r;
  logic signed [ACC_W-1:0]      sh_nxt;
  logic [ACC_W-SB:0]            upper;
  logic                         fits;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = shamt;
      sh_nxt   = acc_in;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        sh_nxt  = {sh_r[ACC_W-1], sh_r[ACC_W-1:1]};
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_comb begin
    upper     = sh_r[ACC_W-1:SB-1];
    fits      = (&upper) | ~(|upper);
    sat_value = fits ? sh_r[SB-1:0] : (sh_r[ACC_W-1] ? SAT_MIN : SAT_MAX);
  end

  assign done = busy_r && (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

endmodule

[hw/rtl/fir_filter_delay_line_unit.sv]
`timescale 1ns / 1ps
// Direct-form FIR filter with a circular delay line and a command interface.
// Each input transaction carries one action (filter a sample, write a
// coefficient, write or read a delay entry, clear the delay line) and yields
// exactly one result transaction. A filtered sample makes one pass over the
// coefficient and delay memories at one multiply-accumulate per tap, then a
// bit-serial right shift of the accumulator, one bit per cycle. Coefficient
// and delay writes go straight to the result state; a delay read passes a
// read state first. Clearing the delay line sweeps its MAX_TAPS-1 entries,
// one entry per cycle; after reset a sweep over all MAX_TAPS entries zeroes
// both memories, during which in_ready stays low.
module fir_filter_delay_line_unit #(
  parameter int MAX_TAPS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  fdl_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output fdl_pkg::out_t                      out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fdl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fdl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SB    = fdl_pkg::SAMPLE_BITS;
  localparam int DLY   = MAX_TAPS - 1;
  localparam int PW    = $clog2(MAX_TAPS);
  localparam int DAW   = (DLY > 1) ? $clog2(DLY) : 1;
  localparam int KW    = (PW + 1 > 7) ? PW + 1 : 7;
  localparam int AW    = KW + 1;
  localparam int ACC_W = 2 * SB + PW;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_PUSH  = 3'd6;

  logic signed [SB-1:0] coef_mem [MAX_TAPS];
  logic signed [SB-1:0] dly_mem  [DLY];

  logic                  coef_we;
  logic [PW-1:0]         coef_wa;
  logic signed [SB-1:0]  coef_wd;
  logic [PW-1:0]         coef_ra;
  logic signed [SB-1:0]  coef_rd_r;
  logic                  dly_we;
  logic [DAW-1:0]        dly_wa;
  logic signed [SB-1:0]  dly_wd;
  logic [DAW-1:0]        dly_ra;
  logic signed [SB-1:0]  dly_rd_r;

  logic [2:0]                       state_r, state_nxt;
  logic [PW-1:0]                    clr_idx_r, clr_idx_nxt;
  logic                             clr_all_r, clr_all_nxt;
  logic [DAW-1:0]                   np_r, np_nxt;
  logic [fdl_pkg::TAPCNT_W-1:0]     tap_count_r, tap_count_nxt;
  logic [fdl_pkg::SHIFT_W-1:0]      out_shift_r, out_shift_nxt;
  logic [KW-1:0]                    k_r, k_nxt;
  logic signed [SB-1:0]             x_r, x_nxt;
  logic                             last_r, last_nxt;
  logic                             err_r, err_nxt;
  logic signed [SB-1:0]             val_r, val_nxt;
  fdl_pkg::mac_ctl_t                mac_ctl_r, mac_ctl_nxt;
  logic                             out_valid_r, out_valid_nxt;
  fdl_pkg::out_t                    out_data_r, out_data_nxt;

  logic [KW-1:0]           tc_k;
  logic [KW-1:0]           eff;
  logic [KW-1:0]           idx_k;
  logic                    coef_ok;
  logic                    dly_ok;
  logic [KW-1:0]           d_sel;
  logic [AW-1:0]           dsum;
  logic [AW-1:0]           dwrap;
  logic [DAW-1:0]          daddr;
  logic [DAW-1:0]          np_dec;
  logic                    tap_last;
  logic                    out_load;
  logic                    sh_start;
  logic signed [SB-1:0]    mac_operand;
  logic signed [ACC_W-1:0] mac_acc;
  logic                    mac_done;
  logic                    sh_done;
  logic signed [SB-1:0]    sat_value;

  always_comb begin
    tc_k    = KW'(tap_count_r);
    if (tc_k == '0) begin
      eff = KW'(1);
    end else if (tc_k > KW'(MAX_TAPS)) begin
      eff = KW'(MAX_TAPS);
    end else begin
      eff = tc_k;
    end
    idx_k    = KW'(in_data.entry_index);
    coef_ok  = idx_k < eff;
    dly_ok   = (idx_k + KW'(1)) < eff;
    d_sel    = (state_r == S_MAC) ? k_r - KW'(1) : idx_k;
    dsum     = AW'(np_r) + AW'(d_sel);
    dwrap    = (dsum >= AW'(DLY)) ? dsum - AW'(DLY) : dsum;
    daddr    = dwrap[DAW-1:0];
    np_dec   = (np_r == '0) ? DAW'(DLY - 1) : np_r - DAW'(1);
    tap_last = k_r == eff - KW'(1);
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    clr_all_nxt   = clr_all_r;
    np_nxt        = np_r;
    k_nxt         = k_r;
    x_nxt         = x_r;
    last_nxt      = last_r;
    err_nxt       = err_r;
    val_nxt       = val_r;
    mac_ctl_nxt   = '0;
    sh_start      = 1'b0;
    out_load      = 1'b0;
    coef_we       = 1'b0;
    coef_wa       = clr_idx_r;
    coef_wd       = '0;
    coef_ra       = k_r[PW-1:0];
    dly_we        = 1'b0;
    dly_wa        = clr_idx_r[DAW-1:0];
    dly_wd        = '0;
    dly_ra        = daddr;

    case (state_r)
      S_CLR: begin
        coef_we     = clr_all_r;
        dly_we      = clr_idx_r < PW'(DLY);
        clr_idx_nxt = clr_idx_r + PW'(1);
        if (clr_idx_r == (clr_all_r ? PW'(MAX_TAPS - 1) : PW'(DLY - 1))) begin
          clr_idx_nxt = '0;
          clr_all_nxt = 1'b0;
          state_nxt   = clr_all_r ? S_IDLE : S_PUSH;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          x_nxt    = in_data.data_value;
          last_nxt = in_data.is_last;
          err_nxt  = 1'b0;
          val_nxt  = '0;
          case (in_data.action)
            fdl_pkg::ACT_SAMPLE: begin
              k_nxt     = '0;
              state_nxt = S_MAC;
            end
            fdl_pkg::ACT_WR_COEF: begin
              if (coef_ok) begin
                coef_we = 1'b1;
                coef_wa = idx_k[PW-1:0];
                coef_wd = in_data.data_value;
              end else begin
                err_nxt = 1'b1;
              end
              state_nxt = S_PUSH;
            end
            fdl_pkg::ACT_WR_DELAY: begin
              if (dly_ok) begin
                dly_we = 1'b1;
                dly_wa = daddr;
                dly_wd = in_data.data_value;
              end else begin
                err_nxt = 1'b1;
              end
              state_nxt = S_PUSH;
            end
            fdl_pkg::ACT_RD_DELAY: begin
              if (dly_ok) begin
                state_nxt = S_READ;
              end else begin
                err_nxt   = 1'b1;
                state_nxt = S_PUSH;
              end
            end
            fdl_pkg::ACT_CLR_DELAY: begin
              np_nxt      = '0;
              clr_idx_nxt = '0;
              clr_all_nxt = 1'b0;
              state_nxt   = S_CLR;
            end
            default: begin
              err_nxt   = 1'b1;
              state_nxt = S_PUSH;
            end
          endcase
        end
      end
      S_MAC: begin
        mac_ctl_nxt.vld   = 1'b1;
        mac_ctl_nxt.first = (k_r == '0);
        mac_ctl_nxt.last  = tap_last;
        k_nxt             = k_r + KW'(1);
        if (tap_last) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (mac_done) begin
          sh_start  = 1'b1;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sh_done) begin
          val_nxt   = sat_value;
          dly_we    = 1'b1;
          dly_wa    = np_dec;
          dly_wd    = x_r;
          np_nxt    = np_dec;
          state_nxt = S_PUSH;
        end
      end
      S_READ: begin
        val_nxt   = dly_rd_r;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    tap_count_nxt = tap_count_r;
    out_shift_nxt = out_shift_r;
    if (cfg_valid) begin
      case (cfg_index)
        fdl_pkg::CFG_TAP_COUNT: tap_count_nxt = cfg_data[fdl_pkg::TAPCNT_W-1:0];
        fdl_pkg::CFG_OUT_SHIFT: out_shift_nxt = cfg_data[fdl_pkg::SHIFT_W-1:0];
        default: begin
          tap_count_nxt = tap_count_r;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.out_value = val_r;
      out_data_nxt.out_last  = last_r;
      out_data_nxt.out_error = err_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      clr_all_r   <= 1'b1;
      np_r        <= '0;
      tap_count_r <= fdl_pkg::TAPCNT_W'(1);
      out_shift_r <= fdl_pkg::SHIFT_W'(15);
      k_r         <= '0;
      mac_ctl_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      clr_all_r   <= clr_all_nxt;
      np_r        <= np_nxt;
      tap_count_r <= tap_count_nxt;
      out_shift_r <= out_shift_nxt;
      k_r         <= k_nxt;
      mac_ctl_r   <= mac_ctl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    last_r     <= last_nxt;
    err_r      <= err_nxt;
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= coef_wd;
    end
    coef_rd_r <= coef_mem[coef_ra];
  end

  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem[dly_wa] <= dly_wd;
    end
    dly_rd_r <= dly_mem[dly_ra];
  end

  assign mac_operand = mac_ctl_r.first ? x_r : dly_rd_r;

  fdl_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl_r),
    .coef    (coef_rd_r),
    .operand (mac_operand),
    .acc     (mac_acc),
    .done    (mac_done)
  );

  fdl_shift_sat #(
    .ACC_W (ACC_W)
  ) u_shift_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (sh_start),
    .acc_in    (mac_acc),
    .shamt     (out_shift_r),
    .done      (sh_done),
    .sat_value (sat_value)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_mac_done_in_acc: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == S_ACC)
    else $error("accumulator finished outside its wait state");

  a_shift_done_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
    sh_done |-> state_r == S_SHIFT)
    else $error("shifter finished outside its wait state");

  a_newest_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    np_r <= DAW'(DLY - 1))
    else $error("newest position beyond delay depth");

  a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && out_valid_r && !out_ready) |=> state_r == S_PUSH)
    else $error("result dropped while output stalled");

endmodule

[tb/tb_fir_filter_delay_line_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the FIR filter delay line unit.
module tb_fir_filter_delay_line_unit;

  localparam int TAP_LIMIT       = 64;
  localparam int DELAY_DEPTH     = TAP_LIMIT - 1;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 128;

  localparam int SB     = fdl_pkg::SAMPLE_BITS;
  localparam int ACT_W  = fdl_pkg::ACTION_W;
  localparam int IDX_W  = fdl_pkg::INDEX_W;
  localparam int CFG_W  = fdl_pkg::CFG_DATA_W;
  localparam int CIDX_W = fdl_pkg::CFG_IDX_W;

  localparam logic [ACT_W-1:0] ACT_UNDEF_LO = fdl_pkg::ACT_CLR_DELAY + 1'b1;
  localparam logic [ACT_W-1:0] ACT_UNDEF_HI = '1;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  fdl_pkg::in_t          in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  fdl_pkg::out_t         out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CIDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  logic steady_flow = 1'b0;
  logic hold_active = 1'b0;
  event start_hold_off;
  int   error_count = 0;

  logic signed [SB-1:0]                coef_mem [TAP_LIMIT];
  logic signed [SB-1:0]                delay_mem [DELAY_DEPTH];
  int unsigned                         newest_pos;
  logic [fdl_pkg::TAPCNT_W-1:0]        tap_count_reg;
  logic [fdl_pkg::SHIFT_W-1:0]         shift_reg;
  fdl_pkg::out_t                       responses_due [$];

  fir_filter_delay_line_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  function automatic int unsigned taps_in_use();
    if (tap_count_reg == 0) return 1;
    if (tap_count_reg > TAP_LIMIT) return TAP_LIMIT;
    return tap_count_reg;
  endfunction

  function automatic fdl_pkg::out_t fir_response(input fdl_pkg::in_t cmd);
    fdl_pkg::out_t        r;
    longint               acc;
    int unsigned          t;
    int unsigned          idx;
    logic signed [SB-1:0] x;
    r = '0;
    r.out_last = cmd.is_last;
    t = taps_in_use();
    idx = cmd.entry_index;
    x = cmd.data_value;
    case (cmd.action)
      fdl_pkg::ACT_SAMPLE: begin
        acc = longint'(coef_mem[0]) * longint'(x);
        for (int unsigned k = 1; k < t; k++)
          acc += longint'(coef_mem[k]) * longint'(delay_mem[(newest_pos + k - 1) % DELAY_DEPTH]);
        acc = acc >>> shift_reg;
        if (acc > 32767) r.out_value = 16'sh7FFF;
        else if (acc < -32768) r.out_value = 16'sh8000;
        else r.out_value = acc[SB-1:0];
        newest_pos = (newest_pos + DELAY_DEPTH - 1) % DELAY_DEPTH;
        delay_mem[newest_pos] = x;
      end
      fdl_pkg::ACT_WR_COEF: begin
        if (idx < t) coef_mem[idx] = x;
        else r.out_error = 1'b1;
      end
      fdl_pkg::ACT_WR_DELAY: begin
        if (idx + 1 < t) delay_mem[(newest_pos + idx) % DELAY_DEPTH] = x;
        else r.out_error = 1'b1;
      end
      fdl_pkg::ACT_RD_DELAY: begin
        if (idx + 1 < t) r.out_value = delay_mem[(newest_pos + idx) % DELAY_DEPTH];
        else r.out_error = 1'b1;
      end
      fdl_pkg::ACT_CLR_DELAY: begin
        for (int k = 0; k < DELAY_DEPTH; k++) delay_mem[k] = '0;
        newest_pos = 0;
      end
      default: r.out_error = 1'b1;
    endcase
    return r;
  endfunction

  function automatic fdl_pkg::in_t make_cmd(input logic [ACT_W-1:0] act,
                                            input int unsigned idx,
                                            input logic signed [SB-1:0] value,
                                            input logic last);
    fdl_pkg::in_t cmd;
    cmd.action = act;
    cmd.entry_index = IDX_W'(idx);
    cmd.data_value = value;
    cmd.is_last = last;
    return cmd;
  endfunction

  function automatic logic signed [SB-1:0] random_value();
    int unsigned          roll;
    logic signed [SB-1:0] v;
    roll = $urandom_range(0, 99);
    if (roll < 8) v = 16'sh7FFF;
    else if (roll < 16) v = 16'sh8000;
    else if (roll < 50) v = SB'(int'($urandom_range(0, 4095)) - 2048);
    else v = SB'($urandom());
    return v;
  endfunction

  // Drive one command transaction and record its response once accepted.
  task automatic issue_command(input fdl_pkg::in_t cmd);
    while (!steady_flow && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    responses_due.push_back(fir_response(cmd));
  endtask

  task automatic write_register(input logic [CIDX_W-1:0] idx,
                                input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == fdl_pkg::CFG_TAP_COUNT) tap_count_reg = data[fdl_pkg::TAPCNT_W-1:0];
    else shift_reg = data[fdl_pkg::SHIFT_W-1:0];
  endtask

  // Drain outstanding responses, then reprogram both registers.
  task automatic set_config(input int unsigned taps, input int unsigned shift);
    logic [1:0] pad;
    pad = 2'($urandom());
    in_valid <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk);
    write_register(fdl_pkg::CFG_TAP_COUNT, CFG_W'(taps));
    write_register(fdl_pkg::CFG_OUT_SHIFT, {pad, shift[fdl_pkg::SHIFT_W-1:0]});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_burst(input int unsigned count);
    int unsigned  sent;
    int unsigned  roll;
    int unsigned  t;
    int unsigned  len;
    fdl_pkg::in_t cmd;
    sent = 0;
    while (sent < count) begin
      t = taps_in_use();
      roll = $urandom_range(0, 99);
      cmd.entry_index = IDX_W'($urandom());
      cmd.data_value = random_value();
      cmd.is_last = 1'($urandom());
      if (roll < 8) begin
        for (int unsigned k = 0; k < t; k++) begin
          issue_command(make_cmd(fdl_pkg::ACT_WR_COEF, k, random_value(), 1'($urandom())));
          sent++;
        end
      end else if (roll < 68) begin
        len = $urandom_range(1, 16);
        for (int unsigned k = 0; k < len; k++) begin
          cmd.action = fdl_pkg::ACT_SAMPLE;
          cmd.entry_index = IDX_W'($urandom());
          cmd.data_value = random_value();
          cmd.is_last = (k == len - 1);
          issue_command(cmd);
          sent++;
        end
      end else if (roll < 86) begin
        cmd.action = (roll < 77) ? fdl_pkg::ACT_WR_DELAY : fdl_pkg::ACT_RD_DELAY;
        if (t > 1 && $urandom_range(0, 3) != 0)
          cmd.entry_index = IDX_W'($urandom_range(0, t - 2));
        issue_command(cmd);
        sent++;
      end else if (roll < 89) begin
        cmd.action = fdl_pkg::ACT_CLR_DELAY;
        issue_command(cmd);
        sent++;
      end else if (roll < 93) begin
        cmd.action = ACT_W'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
        issue_command(cmd);
        sent++;
      end else begin
        cmd.action = fdl_pkg::ACT_WR_COEF;
        issue_command(cmd);
        sent++;
      end
    end
  endtask

  task automatic test_reset_defaults();
    issue_command(make_cmd(fdl_pkg::ACT_RD_DELAY, 0, 16'sh1234, 1'b0));
    issue_command(make_cmd(fdl_pkg::ACT_WR_COEF, 0, 16'sh7FFF, 1'b1));
    issue_command(make_cmd(fdl_pkg::ACT_WR_COEF, 1, 16'sh4000, 1'b0));
    issue_command(make_cmd(fdl_pkg::ACT_SAMPLE, 0, 16'sh7FFF, 1'b1));
  endtask

  task automatic test_tap_count_limits();
    set_config(0, 0);
    issue_command(make_cmd(fdl_pkg::ACT_SAMPLE, 0, 16'sh8000, 1'b0));
    issue_command(make_cmd(fdl_pkg::ACT_WR_COEF, 1, 16'sh0100, 1'b1));
    set_config(127, 31);
    issue_command(make_cmd(fdl_pkg::ACT_WR_COEF, 63, 16'sh8000, 1'b0));
    issue_command(make_cmd(fdl_pkg::ACT_WR_DELAY, 62, 16'sh7FFF, 1'b1));
    issue_command(make_cmd(fdl_pkg::ACT_RD_DELAY, 62, 16'sh0000, 1'b0));
    issue_command(make_cmd(fdl_pkg::ACT_RD_DELAY, 63, 16'shFFFF, 1'b1));
    issue_command(make_cmd(fdl_pkg::ACT_SAMPLE, 63, 16'sh8000, 1'b1));
  endtask

  task automatic test_index_range();
    set_config(8, 15);
    issue_command(make_cmd(fdl_pkg::ACT_WR_COEF, 7, 16'sh2000, 1'b0));
    issue_command(make_cmd(fdl_pkg::ACT_WR_COEF, 8, 16'sh2000, 1'b1));
    issue_command(make_cmd(fdl_pkg::ACT_WR_DELAY, 6, 16'shC000, 1'b0));
    issue_command(make_cmd(fdl_pkg::ACT_WR_DELAY, 7, 16'shC000, 1'b1));
    issue_command(make_cmd(fdl_pkg::ACT_RD_DELAY, 6, 16'sh0000, 1'b0));
    issue_command(make_cmd(fdl_pkg::ACT_RD_DELAY, 7, 16'sh0000, 1'b1));
  endtask

  task automatic test_saturation();
    set_config(64, 0);
    issue_command(make_cmd(fdl_pkg::ACT_SAMPLE, 0, 16'sh7FFF, 1'b0));
    issue_command(make_cmd(fdl_pkg::ACT_SAMPLE, 0, 16'sh8000, 1'b1));
  endtask

  task automatic test_clear_delay();
    issue_command(make_cmd(fdl_pkg::ACT_CLR_DELAY, 0, 16'sh7FFF, 1'b1));
    issue_command(make_cmd(fdl_pkg::ACT_RD_DELAY, 0, 16'sh0000, 1'b0));
    issue_command(make_cmd(fdl_pkg::ACT_SAMPLE, 0, 16'sh0001, 1'b1));
  endtask

  task automatic test_undefined_actions();
    issue_command(make_cmd(ACT_UNDEF_LO, 63, 16'sh7FFF, 1'b1));
    issue_command(make_cmd(ACT_W'(ACT_UNDEF_LO + 1), 0, 16'sh8000, 1'b0));
    issue_command(make_cmd(ACT_UNDEF_HI, 63, 16'shFFFF, 1'b1));
  endtask

  task automatic test_random_filtering();
    int unsigned roll;
    int unsigned taps;
    int unsigned shift;
    for (int phase = 0; phase < 7; phase++) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) taps = $urandom_range(1, 10);
      else if (roll < 70) taps = $urandom_range(11, 40);
      else if (roll < 80) taps = TAP_LIMIT;
      else if (roll < 86) taps = 0;
      else if (roll < 93) taps = $urandom_range(65, 127);
      else taps = $urandom_range(41, 63);
      shift = ($urandom_range(0, 99) < 70) ? $urandom_range(10, 18) : $urandom_range(0, 31);
      set_config(taps, shift);
      send_random_burst(220);
    end
  endtask

  task automatic test_steady_stream();
    set_config($urandom_range(2, 12), 15);
    steady_flow <= 1'b1;
    send_random_burst(150);
    steady_flow <= 1'b0;
  endtask

  task automatic test_output_hold_off();
    set_config($urandom_range(1, 6), 14);
    -> start_hold_off;
    send_random_burst(80);
  endtask

  always @(posedge clk) begin
    if (!rst_n || hold_active) out_ready <= 1'b0;
    else out_ready <= steady_flow || ($urandom_range(0, 99) >= 33);
  end

  always begin
    @(start_hold_off);
    hold_active <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  always @(posedge clk) begin : check_responses
    fdl_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (responses_due.size() == 0) begin
        report_mismatch($sformatf("response %h with none outstanding", out_data));
      end else begin
        want = responses_due.pop_front();
        if (out_data.out_value !== want.out_value)
          report_mismatch($sformatf("out_value %0d, want %0d",
                                    out_data.out_value, want.out_value));
        if (out_data.out_last !== want.out_last)
          report_mismatch($sformatf("out_last %b, want %b", out_data.out_last, want.out_last));
        if (out_data.out_error !== want.out_error)
          report_mismatch($sformatf("out_error %b, want %b",
                                    out_data.out_error, want.out_error));
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (int k = 0; k < TAP_LIMIT; k++) coef_mem[k] = '0;
    for (int k = 0; k < DELAY_DEPTH; k++) delay_mem[k] = '0;
    newest_pos    = 0;
    tap_count_reg = 1;
    shift_reg     = 15;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_tap_count_limits();
    test_index_range();
    test_saturation();
    test_clear_delay();
    test_undefined_actions();
    test_random_filtering();
    test_steady_stream();
    test_output_hold_off();

    in_valid <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_fir_filter_delay_line_unit passed");
    end else begin
      $display("tb_fir_filter_delay_line_unit failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_fir_filter_delay_line_unit failed");
    $finish;
  end

endmodule
